FILE: rtl/core/lpp_pkg.sv
// Shared types, constants and the control-store program for the LED PWM phase packer.
// No dependencies; imported by every module under rtl/core.
package lpp_pkg;

	localparam int DEF_NUM_CHANNELS = 12;

	localparam logic CMD_SET  = 1'b0;
	localparam logic CMD_SEND = 1'b1;

	localparam logic [1:0]  TGT_MASK   = 2'd3;
	localparam logic [15:0] FULL_POWER = 16'hFFFF;

	// control store addressing
	localparam int          STEP_W     = 4;
	localparam logic [3:0]  UC_SELECT  = 4'd0;
	localparam logic [3:0]  UC_NEXT    = 4'd11;

	typedef enum logic [2:0] {
		BK_ON_LO,
		BK_OFF_LO,
		BK_ON_HI,
		BK_OFF_HI,
		BK_MASK_LO,
		BK_MASK_HI
	} byte_kind_t;

	typedef enum logic [1:0] {
		BR_SEQ,   // fall through
		BR_SKIP,  // jump to dest when the current group is not selected
		BR_LOOP,  // next group and jump to dest, fall through after the last group
		BR_END    // send finished
	} branch_t;

	typedef struct packed {
		logic       emit;
		byte_kind_t kind;
		logic [1:0] lane;
		logic [3:0] bidx;
		logic       last;
		branch_t    br;
		logic [3:0] dest;
	} uc_word_t;

	// sequencer -> byte path
	typedef struct packed {
		logic       adv;   // control word retires this cycle
		logic       emit;
		byte_kind_t kind;
		logic [1:0] lane;
		logic [3:0] bidx;
		logic       last;
		logic [1:0] grp;
	} lpp_ctl_t;

	function automatic uc_word_t uc_rom(input logic [STEP_W-1:0] step);
		uc_word_t w;
		case (step)
			4'd0:  w = '{1'b0, BK_ON_LO,   2'd0, 4'd0, 1'b0, BR_SKIP, UC_NEXT};
			4'd1:  w = '{1'b1, BK_ON_LO,   2'd0, 4'd0, 1'b0, BR_SEQ,  UC_SELECT};
			4'd2:  w = '{1'b1, BK_ON_LO,   2'd1, 4'd1, 1'b0, BR_SEQ,  UC_SELECT};
			4'd3:  w = '{1'b1, BK_ON_LO,   2'd2, 4'd2, 1'b0, BR_SEQ,  UC_SELECT};
			4'd4:  w = '{1'b1, BK_ON_LO,   2'd3, 4'd3, 1'b0, BR_SEQ,  UC_SELECT};
			4'd5:  w = '{1'b1, BK_OFF_LO,  2'd0, 4'd4, 1'b0, BR_SEQ,  UC_SELECT};
			4'd6:  w = '{1'b1, BK_OFF_LO,  2'd1, 4'd5, 1'b0, BR_SEQ,  UC_SELECT};
			4'd7:  w = '{1'b1, BK_OFF_LO,  2'd2, 4'd6, 1'b0, BR_SEQ,  UC_SELECT};
			4'd8:  w = '{1'b1, BK_OFF_LO,  2'd3, 4'd7, 1'b0, BR_SEQ,  UC_SELECT};
			4'd9:  w = '{1'b1, BK_ON_HI,   2'd0, 4'd8, 1'b0, BR_SEQ,  UC_SELECT};
			4'd10: w = '{1'b1, BK_OFF_HI,  2'd0, 4'd9, 1'b0, BR_SEQ,  UC_SELECT};
			4'd11: w = '{1'b0, BK_ON_LO,   2'd0, 4'd0, 1'b0, BR_LOOP, UC_SELECT};
			4'd12: w = '{1'b1, BK_MASK_LO, 2'd0, 4'd0, 1'b0, BR_SEQ,  UC_SELECT};
			4'd13: w = '{1'b1, BK_MASK_HI, 2'd0, 4'd1, 1'b1, BR_END,  UC_SELECT};
			default: w = '{1'b0, BK_ON_LO, 2'd0, 4'd0, 1'b0, BR_END,  UC_SELECT};
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/core/lpp_chan_store.sv
// Per-channel brightness registers with one write port, one read port and the enable mask.
// Depends on lpp_pkg.
module lpp_chan_store
	import lpp_pkg::*;
#(
	parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [3:0]  wr_ch,
	input  logic [15:0] wr_power,
	input  logic [3:0]  rd_ch,
	output logic [15:0] rd_power,
	output logic [15:0] mask
);

	localparam int CH_W = $clog2(NUM_CHANNELS);

	logic [15:0] pwr_q [NUM_CHANNELS];
	logic        wr_ok;
	logic        rd_ok;

	assign wr_ok = ({1'b0, wr_ch} < 5'(NUM_CHANNELS));
	assign rd_ok = ({1'b0, rd_ch} < 5'(NUM_CHANNELS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				pwr_q[i] <= '0;
			end
		end else if (wr_en && wr_ok) begin
			pwr_q[wr_ch[CH_W-1:0]] <= wr_power;
		end
	end

	// slots past the last channel read as zero power
	assign rd_power = rd_ok ? pwr_q[rd_ch[CH_W-1:0]] : 16'h0000;

	for (genvar i = 0; i < 16; i++) begin : g_mask
		if (i < NUM_CHANNELS) begin : g_live
			assign mask[i] = |pwr_q[i];
		end else begin : g_none
			assign mask[i] = 1'b0;
		end
	end

endmodule

FILE: rtl/core/lpp_sequencer.sv
// Step counter, group counter and branch logic walking the control-store program.
// Depends on lpp_pkg (program table, control word types).
module lpp_sequencer
	import lpp_pkg::*;
#(
	parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [3:0] first_ch,
	input  logic [3:0] last_ch,
	input  logic       out_free,
	output logic       busy,
	output lpp_ctl_t   ctl
);

	localparam int         GROUPS_RAW = NUM_CHANNELS / 4;
	localparam int         NUM_GROUPS = (GROUPS_RAW > 3) ? 3 : GROUPS_RAW;
	localparam logic [1:0] LAST_GRP   = 2'(NUM_GROUPS - 1);

	logic [STEP_W-1:0] step_q;
	logic [1:0]        grp_q;
	logic              busy_q;
	logic [3:0]        first_q;
	logic [3:0]        last_q;
	uc_word_t          cw;
	logic              adv;
	logic              lo_ok;
	logic              hi_ok;
	logic              sel;

	assign cw  = uc_rom(step_q);
	assign adv = busy_q && (!cw.emit || out_free);

	assign lo_ok = (grp_q == 2'd0) || (last_q >= {grp_q, 2'b00});
	assign hi_ok = (grp_q == LAST_GRP) || (first_q <= {grp_q, 2'b11});
	assign sel   = lo_ok && hi_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= UC_SELECT;
			grp_q   <= 2'd0;
			busy_q  <= 1'b0;
			first_q <= 4'd0;
			last_q  <= 4'd0;
		end else if (start) begin
			step_q  <= UC_SELECT;
			grp_q   <= 2'd0;
			busy_q  <= 1'b1;
			first_q <= first_ch;
			last_q  <= last_ch;
		end else if (adv) begin
			case (cw.br)
				BR_SEQ: begin
					step_q <= step_q + 1'b1;
				end
				BR_SKIP: begin
					step_q <= sel ? step_q + 1'b1 : cw.dest;
				end
				BR_LOOP: begin
					if (grp_q != LAST_GRP) begin
						grp_q  <= grp_q + 1'b1;
						step_q <= cw.dest;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				BR_END: begin
					busy_q <= 1'b0;
					step_q <= UC_SELECT;
				end
				default: begin
					busy_q <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign ctl  = '{adv, cw.emit, cw.kind, cw.lane, cw.bidx, cw.last, grp_q};

	a_grp_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> grp_q <= LAST_GRP)
		else $error("group counter past last group");

	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		adv && cw.br == BR_END |=> !busy_q)
		else $error("sequencer still busy after end step");

endmodule

FILE: rtl/core/lpp_byte_path.sv
// Datapath: channel timing (on/off times), high-bit accumulators and frame byte select.
// Depends on lpp_pkg (control struct, byte kinds).
module lpp_byte_path
	import lpp_pkg::*;
(
	input  logic        clk,
	input  lpp_ctl_t    ctl,
	input  logic [15:0] rd_power,
	input  logic [15:0] mask,
	output logic [3:0]  rd_ch,
	output logic [7:0]  byte_data,
	output logic [1:0]  target
);

	logic        zero_p;
	logic        full_p;
	logic [16:0] ceil_sum;
	logic [9:0]  off_sum;
	logic [9:0]  on_t;
	logic [9:0]  off_t;
	logic [7:0]  on_hi_q;
	logic [7:0]  off_hi_q;
	logic        frame_kind;

	assign rd_ch = {ctl.grp, ctl.lane};

	assign zero_p   = (rd_power == 16'h0000);
	assign full_p   = (rd_power == FULL_POWER);
	// ceil(p/64), wrapped to 10 bits with the base
	assign ceil_sum = {1'b0, rd_power} + 17'd63;
	assign off_sum  = {ctl.grp, 8'h00} + ceil_sum[15:6];

	assign on_t  = full_p ? 10'd0 : {ctl.grp, 8'h00};
	assign off_t = zero_p ? {ctl.grp, 8'h01} : (full_p ? 10'h3FF : off_sum);

	// lane 0 ends in bits 7:6 after four shifts
	always_ff @(posedge clk) begin
		if (ctl.adv && ctl.emit && ctl.kind == BK_ON_LO) begin
			on_hi_q <= {on_hi_q[5:0], on_t[9:8]};
		end
		if (ctl.adv && ctl.emit && ctl.kind == BK_OFF_LO) begin
			off_hi_q <= {off_hi_q[5:0], off_t[9:8]};
		end
	end

	always_comb begin
		frame_kind = 1'b1;
		case (ctl.kind)
			BK_ON_LO:   byte_data = on_t[7:0];
			BK_OFF_LO:  byte_data = off_t[7:0];
			BK_ON_HI:   byte_data = on_hi_q;
			BK_OFF_HI:  byte_data = off_hi_q;
			BK_MASK_LO: begin
				byte_data  = mask[7:0];
				frame_kind = 1'b0;
			end
			BK_MASK_HI: begin
				byte_data  = mask[15:8];
				frame_kind = 1'b0;
			end
			default:    byte_data = 8'h00;
		endcase
	end

	assign target = frame_kind ? ctl.grp : TGT_MASK;

endmodule

FILE: rtl/core/led_pwm_phase_packer.sv
// Top level of the LED PWM phase packer: stream ports, output register and glue.
// Depends on lpp_pkg, lpp_chan_store, lpp_sequencer, lpp_byte_path.
//
// Usage:
//  - Input stream (s_axis_*): tuser carries the command. A set word (command 0) writes
//    channel's brightness in the cycle it is accepted and produces nothing. A send word
//    (command 1) emits the timing frames of the selected groups, then two mask bytes.
//  - Output stream (m_axis_*): one byte per word; tuser is the target (0..2 group frame,
//    3 enable mask), tdata holds byte_index and data, tlast marks the mask high byte.
//  - Timing: a set never makes the input busy. A send is run by a 14-step microprogram,
//    one control word per cycle unless an emitting step waits for the output register:
//    a skipped group runs only its select and loop steps, a sent group runs every step
//    from select through loop, and the mask steps close the send. The first byte enters the
//    output register on the first emitting step, after the steps of any skipped groups.
//  - s_axis_tready is low while a send is being sequenced and rises at the edge that
//    loads the last byte, so a new word may be taken while that byte still waits downstream.
//  - Backpressure: the single output register holds its byte while m_axis_tready is low;
//    the sequencer freezes on any emitting step until the register frees up.
//  - Reset (arst_n low) clears all brightness values to zero, idles the sequencer and
//    drops m_axis_tvalid.
module led_pwm_phase_packer
	import lpp_pkg::*;
#(
	parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // channel[3:0], power[19:4], first_channel[23:20],
	                                   // last_channel[27:24], zero fill [31:28]
	input  logic        s_axis_tuser,  // command[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // byte_index[3:0], data[11:4], zero fill [15:12]
	output logic [1:0]  m_axis_tuser,  // target[1:0]
	output logic        m_axis_tlast   // last
);

	logic        s_fire;
	logic        busy;
	logic        out_free;
	logic        out_load;
	lpp_ctl_t    ctl;
	logic [3:0]  rd_ch;
	logic [15:0] rd_power;
	logic [15:0] mask;
	logic [7:0]  byte_data;
	logic [1:0]  target;

	logic        m_valid_q;
	logic [3:0]  m_bidx_q;
	logic [7:0]  m_data_q;
	logic [1:0]  m_tgt_q;
	logic        m_last_q;

	assign s_axis_tready = !busy;
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	lpp_chan_store #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (s_fire && s_axis_tuser == CMD_SET),
		.wr_ch    (s_axis_tdata[3:0]),
		.wr_power (s_axis_tdata[19:4]),
		.rd_ch    (rd_ch),
		.rd_power (rd_power),
		.mask     (mask)
	);

	lpp_sequencer #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (s_fire && s_axis_tuser == CMD_SEND),
		.first_ch (s_axis_tdata[23:20]),
		.last_ch  (s_axis_tdata[27:24]),
		.out_free (out_free),
		.busy     (busy),
		.ctl      (ctl)
	);

	lpp_byte_path u_path (
		.clk       (clk),
		.ctl       (ctl),
		.rd_power  (rd_power),
		.mask      (mask),
		.rd_ch     (rd_ch),
		.byte_data (byte_data),
		.target    (target)
	);

	// output register: refilled in the same cycle the held word is taken
	assign out_free = !m_valid_q || m_axis_tready;
	assign out_load = ctl.adv && ctl.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_bidx_q <= ctl.bidx;
			m_data_q <= byte_data;
			m_tgt_q  <= target;
			m_last_q <= ctl.last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {4'h0, m_data_q, m_bidx_q};
	assign m_axis_tuser  = m_tgt_q;
	assign m_axis_tlast  = m_last_q;

	a_last_is_mask: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == TGT_MASK)
		else $error("tlast on a non-mask byte");

	a_send_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && s_axis_tuser == CMD_SEND |=> !s_axis_tready)
		else $error("send accepted but sequencer not running");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_axis_tready |-> !out_load)
		else $error("output register overwritten while stalled");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && ctl.last |=> s_axis_tready)
		else $error("input not reopened after final byte");

endmodule
